>>> rtl/integer_matrix_multiply_top_defines.svh
// Assertion macros shared by the matrix multiplier RTL.
// Each macro checks a property on the rising edge of the given clock and is
// disabled while the given reset is high.
`ifndef INTEGER_MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Condition a implies condition b in the same cycle.
`define IMM_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("matrix multiplier: implication check failed");

// Condition a implies condition b in the following cycle.
`define IMM_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("matrix multiplier: next-cycle check failed");

`else

`define IMM_ASSERT_IMPLIES(label, clk, rst, a, b)
`define IMM_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

>>> rtl/imm_pkg.sv
package imm_pkg;

  // Fixed field widths of the request and result channels.
  localparam int OPCODE_BITS    = 2;
  localparam int INDEX_BITS     = 3;
  localparam int ELEMENT_BITS   = 16;
  localparam int PV_BITS        = 35;
  localparam int CFG_DATA_BITS  = 4;
  localparam int CFG_INDEX_BITS = 3;

  // Request opcodes.
  localparam logic [OPCODE_BITS-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROWS_A = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLS_A = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROWS_B = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLS_B = 3'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_ERROR
  } state_t;

  // Tag that travels with each multiply-accumulate operand pair.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_tag_t;

endpackage

>>> rtl/imm_ram.sv
module imm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/imm_mac.sv
module imm_mac #(
  parameter int ELEM_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  imm_pkg::mac_tag_t                   issue_tag,
  input  logic [ELEM_BITS-1:0]                a_data,
  input  logic [ELEM_BITS-1:0]                b_data,
  output logic signed [imm_pkg::PV_BITS-1:0]  acc,
  output logic                                done
);

  localparam int PW = 2 * ELEM_BITS;

  imm_pkg::mac_tag_t      tag_rd;
  imm_pkg::mac_tag_t      tag_mul;
  logic signed [PW-1:0]   prod;
  logic signed [63:0]     prod_ext;

  // Tags follow the memory read latency, then the multiplier stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd  <= '0;
      tag_mul <= '0;
      done    <= 1'b0;
    end else begin
      tag_rd  <= issue_tag;
      tag_mul <= tag_rd;
      done    <= tag_mul.valid && tag_mul.last;
    end
  end

  // Multiplier stage on the registered memory data.
  always_ff @(posedge clk) begin
    if (tag_rd.valid) begin
      prod <= $signed(a_data) * $signed(b_data);
    end
  end

  // The sum wraps at the result width.
  assign prod_ext = 64'(prod);

  // Accumulator stage; the first term of an element restarts the sum.
  always_ff @(posedge clk) begin
    if (tag_mul.valid) begin
      if (tag_mul.first) begin
        acc <= prod_ext[imm_pkg::PV_BITS-1:0];
      end else begin
        acc <= acc + prod_ext[imm_pkg::PV_BITS-1:0];
      end
    end
  end

endmodule

>>> rtl/integer_matrix_multiply_top.sv
// Load requests are accepted back to back.
// A compute request stalls the request channel until its last result has been
// emitted: each product element issues cols_a reads, one a cycle, from the two
// element memories, then drains the read, multiply and accumulate stages.
// A dimension error returns its single result through the error state and the result register.
// Reset clears control state and sets all dimensions to 1; memory is not cleared.
`include "integer_matrix_multiply_top_defines.svh"

module integer_matrix_multiply_top #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // Configuration write port.
  input  logic                                     cfg_we,
  input  logic [imm_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [imm_pkg::CFG_DATA_BITS-1:0]        cfg_data,
  // Request channel.
  input  logic                                     cmd_valid,
  output logic                                     cmd_stall,
  input  logic [imm_pkg::OPCODE_BITS-1:0]          opcode,
  input  logic [imm_pkg::INDEX_BITS-1:0]           row_index,
  input  logic [imm_pkg::INDEX_BITS-1:0]           col_index,
  input  logic signed [imm_pkg::ELEMENT_BITS-1:0]  element,
  // Result channel.
  output logic                                     res_valid,
  input  logic                                     res_stall,
  output logic signed [imm_pkg::PV_BITS-1:0]       product_value,
  output logic [imm_pkg::INDEX_BITS-1:0]           out_row,
  output logic [imm_pkg::INDEX_BITS-1:0]           out_col,
  output logic                                     dim_error,
  output logic                                     last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);

  imm_pkg::state_t state;
  imm_pkg::state_t state_next;

  logic [imm_pkg::CFG_DATA_BITS-1:0] rows_a;
  logic [imm_pkg::CFG_DATA_BITS-1:0] cols_a;
  logic [imm_pkg::CFG_DATA_BITS-1:0] rows_b;
  logic [imm_pkg::CFG_DATA_BITS-1:0] cols_b;
  logic [DW-1:0] ra;
  logic [DW-1:0] ca;
  logic [DW-1:0] rb;
  logic [DW-1:0] cb;

  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic [IW-1:0] k;

  logic cmd_accept;
  logic compute_req;
  logic load_in_range;
  logic we_a;
  logic we_b;
  logic [AW-1:0] load_addr;
  logic [ELEM_BITS+imm_pkg::ELEMENT_BITS-1:0] element_wide;
  logic [ELEM_BITS-1:0] load_data;

  logic issue;
  logic last_k;
  logic last_elem;
  logic elem_ready;
  logic slot_free;
  logic emit_elem;
  logic emit_err;
  logic acc_done;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [ELEM_BITS-1:0] a_data;
  logic [ELEM_BITS-1:0] b_data;
  imm_pkg::mac_tag_t issue_tag;
  logic signed [imm_pkg::PV_BITS-1:0] mac_acc;
  logic mac_done;

  // Clamp a dimension register into 1..MAX_DIM.
  function automatic logic [DW-1:0] sat_dim(input logic [imm_pkg::CFG_DATA_BITS-1:0] d);
    logic [DW-1:0] r;
    if (d == '0) begin
      r = DW'(1);
    end else if (int'(d) > MAX_DIM) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(d);
    end
    return r;
  endfunction

  assign ra = sat_dim(rows_a);
  assign ca = sat_dim(cols_a);
  assign rb = sat_dim(rows_b);
  assign cb = sat_dim(cols_b);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= 4'd1;
      cols_a <= 4'd1;
      rows_b <= 4'd1;
      cols_b <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        imm_pkg::CFG_ROWS_A: rows_a <= cfg_data;
        imm_pkg::CFG_COLS_A: cols_a <= cfg_data;
        imm_pkg::CFG_ROWS_B: rows_b <= cfg_data;
        imm_pkg::CFG_COLS_B: cols_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request decode and element loads.
  assign cmd_accept    = cmd_valid && !cmd_stall;
  assign compute_req   = cmd_accept && (opcode == imm_pkg::OP_COMPUTE);
  assign load_in_range = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
  assign we_a = cmd_accept && (opcode == imm_pkg::OP_LOAD_A) && load_in_range;
  assign we_b = cmd_accept && (opcode == imm_pkg::OP_LOAD_B) && load_in_range;
  assign load_addr    = AW'(int'(row_index) * MAX_DIM + int'(col_index));
  assign element_wide = {ELEM_BITS'(0), element};
  assign load_data    = element_wide[ELEM_BITS-1:0];

  // Read addresses for the current term of the dot product.
  assign addr_a = AW'(int'(i) * MAX_DIM + int'(k));
  assign addr_b = AW'(int'(k) * MAX_DIM + int'(j));

  imm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_BITS)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (load_addr),
    .wdata (load_data),
    .re    (issue),
    .raddr (addr_a),
    .rdata (a_data)
  );

  imm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ELEM_BITS)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (load_addr),
    .wdata (load_data),
    .re    (issue),
    .raddr (addr_b),
    .rdata (b_data)
  );

  // Multiply-accumulate pipeline.
  assign issue_tag.valid = issue;
  assign issue_tag.first = (k == '0);
  assign issue_tag.last  = last_k;

  imm_mac #(
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .issue_tag (issue_tag),
    .a_data    (a_data),
    .b_data    (b_data),
    .acc       (mac_acc),
    .done      (mac_done)
  );

  // Walk position flags.
  assign last_k     = (DW'(k) + DW'(1)) == ca;
  assign last_elem  = ((DW'(i) + DW'(1)) == ra) && ((DW'(j) + DW'(1)) == cb);
  assign elem_ready = acc_done || mac_done;
  assign slot_free  = !res_valid || !res_stall;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      imm_pkg::ST_IDLE: begin
        if (compute_req) begin
          state_next = (rb != ca) ? imm_pkg::ST_ERROR : imm_pkg::ST_ISSUE;
        end
      end
      imm_pkg::ST_ISSUE: begin
        if (last_k) begin
          state_next = imm_pkg::ST_WAIT;
        end
      end
      imm_pkg::ST_WAIT: begin
        if (elem_ready && slot_free) begin
          state_next = last_elem ? imm_pkg::ST_IDLE : imm_pkg::ST_ISSUE;
        end
      end
      imm_pkg::ST_ERROR: begin
        if (slot_free) begin
          state_next = imm_pkg::ST_IDLE;
        end
      end
      default: state_next = imm_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    cmd_stall = 1'b1;
    issue     = 1'b0;
    emit_elem = 1'b0;
    emit_err  = 1'b0;
    case (state)
      imm_pkg::ST_IDLE:  cmd_stall = 1'b0;
      imm_pkg::ST_ISSUE: issue = 1'b1;
      imm_pkg::ST_WAIT:  emit_elem = elem_ready && slot_free;
      imm_pkg::ST_ERROR: emit_err = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Row, column and term counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
      k <= '0;
    end else if (compute_req) begin
      i <= '0;
      j <= '0;
      k <= '0;
    end else if (issue) begin
      k <= last_k ? '0 : k + IW'(1);
    end else if (emit_elem) begin
      if ((DW'(j) + DW'(1)) == cb) begin
        j <= '0;
        i <= i + IW'(1);
      end else begin
        j <= j + IW'(1);
      end
    end
  end

  // Holds a finished sum until the result register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_done <= 1'b0;
    end else if (emit_elem) begin
      acc_done <= 1'b0;
    end else if (mac_done) begin
      acc_done <= 1'b1;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_elem || emit_err) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (emit_elem) begin
      product_value <= mac_acc;
      out_row       <= imm_pkg::INDEX_BITS'(i);
      out_col       <= imm_pkg::INDEX_BITS'(j);
      dim_error     <= 1'b0;
      last          <= last_elem;
    end else if (emit_err) begin
      product_value <= '0;
      out_row       <= '0;
      out_col       <= '0;
      dim_error     <= 1'b1;
      last          <= 1'b1;
    end
  end

  // A sum completes only while the sequencer waits for it.
  `IMM_ASSERT_IMPLIES(a_done_in_wait, clk, rst, mac_done, state == imm_pkg::ST_WAIT)
  // No finished sum is pending while the next element is being issued.
  `IMM_ASSERT_IMPLIES(a_issue_clean, clk, rst, state == imm_pkg::ST_ISSUE, !acc_done && !mac_done)
  // An error result is always the single, final, zeroed result.
  `IMM_ASSERT_IMPLIES(a_error_form, clk, rst, res_valid && dim_error, last && (product_value == '0))
  // An emitted element or error result always sets the result valid register.
  `IMM_ASSERT_NEXT(a_emit_shows, clk, rst, emit_elem || emit_err, res_valid)

endmodule
